// File: rtl/sorted_frequency_list_defines.svh
// Assertion macros used by the checker file rtl/sfl_check.sv.
`ifndef SORTED_FREQUENCY_LIST_DEFINES_SVH
`define SORTED_FREQUENCY_LIST_DEFINES_SVH

// Same-cycle implication.
`define SFL_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted_frequency_list assertion failed");

// Next-cycle implication.
`define SFL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted_frequency_list assertion failed");

`endif

// File: rtl/sfl_pkg.sv
`default_nettype none
package sfl_pkg;

  localparam int SYM_W   = 8;
  localparam int FREQ_W  = 32;
  localparam int RANK_W  = 8;
  localparam int COUNT_W = 9;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_READ   = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;
  localparam cmd_t CMD_NOP    = 2'd3;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_ZERO  = 2'd1;
  localparam status_t ST_FULL  = 2'd2;
  localparam status_t ST_RANGE = 2'd3;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [FREQ_W-1:0] freq;
  } entry_t;

endpackage
`default_nettype wire

// File: rtl/sfl_if.sv
`default_nettype none
interface sfl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  symbol;
  logic [31:0] frequency;
  logic [7:0]  rank;

  modport source (output valid, command, symbol, frequency, rank, input ready);
  modport sink   (input valid, command, symbol, frequency, rank, output ready);
endinterface

interface sfl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  read_symbol;
  logic [31:0] read_frequency;
  logic [8:0]  entry_total;

  modport source (output valid, status, read_symbol, read_frequency, entry_total,
                  input ready);
  modport sink   (input valid, status, read_symbol, read_frequency, entry_total,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/sfl_ram.sv
`default_nettype none
module sfl_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire sfl_pkg::entry_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output sfl_pkg::entry_t      rdata_r
);
  import sfl_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/sorted_frequency_list.sv
// sorted_frequency_list: list of (symbol, frequency) pairs kept in ascending
// frequency order, e.g. to seed a Huffman tree build.
// Channels: in_ch (sink) carries command/symbol/frequency/rank, out_ch
// (source) returns one result per input transfer: status, read_symbol,
// read_frequency and entry_total. Both use valid/ready; a transfer happens
// on a rising edge with valid and ready high.
// One item is worked on at a time. The result waits in S_POST and is
// registered when out_ch is free; clear, no-op, zero-count and full inserts
// go there at once, a read first through S_READ. An insert walks the list
// from its tail in S_SCAN through the single-port-read entry RAM, one entry
// per cycle, moving each entry with frequency equal to or above the new one
// up one slot until the insertion point; if that is slot 0, S_PUT writes it.
// The result sits in an output register; in_ch takes the next item while it
// waits, and a finished item waits in place until out_ch is free.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. RAM contents are never cleared; only slots below the count are
// ever read.
`default_nettype none
module sorted_frequency_list #(
  parameter int ENTRIES = 256
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sfl_in_if.sink      in_ch,
  sfl_out_if.source   out_ch
);
  import sfl_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,  // walking down the list, shifting entries up
    S_PUT  = 5'b00100,  // new entry goes into slot 0
    S_READ = 5'b01000,  // RAM data for a read is back
    S_POST = 5'b10000   // result waits for the output register
  } state_t;

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;     // slot whose data comes back now
  entry_t               new_r, new_nxt;     // entry being inserted
  status_t              res_status_r, res_status_nxt;
  logic [SYM_W-1:0]     res_sym_r, res_sym_nxt;
  logic [FREQ_W-1:0]    res_freq_r, res_freq_nxt;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [SYM_W-1:0]     out_sym_r;
  logic [FREQ_W-1:0]    out_freq_r;
  logic [COUNT_W-1:0]   out_total_r;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  entry_t               ram_rdata;

  logic                 in_xfer;
  logic                 out_free;

  sfl_ram #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    new_nxt        = new_r;
    res_status_nxt = res_status_r;
    res_sym_nxt    = res_sym_r;
    res_freq_nxt   = res_freq_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r + AW'(1);
    ram_wdata      = new_r;
    ram_re         = 1'b0;
    ram_raddr      = idx_r - AW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          res_status_nxt = ST_OK;
          res_sym_nxt    = '0;
          res_freq_nxt   = '0;
          new_nxt.sym    = in_ch.symbol;
          new_nxt.freq   = in_ch.frequency;
          state_nxt      = S_POST;
          unique case (in_ch.command)
            CMD_INSERT: begin
              if (in_ch.frequency == '0) begin
                res_status_nxt = ST_ZERO;
              end else if (count_r >= FULL_COUNT) begin
                res_status_nxt = ST_FULL;
              end else if (count_r == '0) begin
                state_nxt = S_PUT;
              end else begin
                // start at the tail
                ram_re    = 1'b1;
                ram_raddr = AW'(count_r - COUNT_W'(1));
                idx_nxt   = AW'(count_r - COUNT_W'(1));
                state_nxt = S_SCAN;
              end
            end
            CMD_READ: begin
              if ({1'b0, in_ch.rank} < count_r) begin
                ram_re    = 1'b1;
                ram_raddr = in_ch.rank[AW-1:0];
                state_nxt = S_READ;
              end else begin
                res_status_nxt = ST_RANGE;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_we = 1'b1;
        if (ram_rdata.freq >= new_r.freq) begin
          // move this entry up one slot, new one goes below it
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            ram_re  = 1'b1;
            idx_nxt = idx_r - AW'(1);
          end
        end else begin
          ram_wdata = new_r;
          count_nxt = count_r + COUNT_W'(1);
          state_nxt = S_POST;
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = new_r;
        count_nxt = count_r + COUNT_W'(1);
        state_nxt = S_POST;
      end
      S_READ: begin
        res_sym_nxt  = ram_rdata.sym;
        res_freq_nxt = ram_rdata.freq;
        state_nxt    = S_POST;
      end
      S_POST: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_POST && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    new_r        <= new_nxt;
    res_status_r <= res_status_nxt;
    res_sym_r    <= res_sym_nxt;
    res_freq_r   <= res_freq_nxt;
    if (state_r == S_POST && out_free) begin
      out_status_r <= res_status_r;
      out_sym_r    <= res_sym_r;
      out_freq_r   <= res_freq_r;
      out_total_r  <= count_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.read_symbol    = out_sym_r;
  assign out_ch.read_frequency = out_freq_r;
  assign out_ch.entry_total    = out_total_r;
endmodule
`default_nettype wire

// File: rtl/sfl_check.sv
`default_nettype none
`include "sorted_frequency_list_defines.svh"
module sfl_check #(
  parameter int ENTRIES = 256
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [7:0]  out_read_symbol,
  input wire logic [31:0] out_read_frequency,
  input wire logic [8:0]  out_entry_total
);
  import sfl_pkg::*;

  // stalled result holds
  `SFL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_entry_total) && $stable(out_read_frequency))

  // one item at a time: no second transfer right after a transfer
  `SFL_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

  // list never holds more than its depth
  `SFL_ASSERT_SAME(a_total_bound, clk, rst_n, out_valid, out_entry_total <= 9'(ENTRIES))

  // failed items (zero, full, range) carry zero read fields
  `SFL_ASSERT_SAME(a_fail_zero, clk, rst_n, out_valid && (out_status == ST_ZERO || out_status == ST_FULL || out_status == ST_RANGE), out_read_symbol == '0 && out_read_frequency == '0)
endmodule

bind sorted_frequency_list sfl_check #(
  .ENTRIES (ENTRIES)
) u_sfl_check (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_read_symbol    (out_ch.read_symbol),
  .out_read_frequency (out_ch.read_frequency),
  .out_entry_total    (out_ch.entry_total)
);
`default_nettype wire
